>>> hw/rtl/lcdr_pkg.sv
package lcdr_pkg;

  // Store geometry
  localparam int DISPLAY_DEPTH = 80;
  localparam int GLYPH_DEPTH   = 64;
  localparam int DISP_AW       = $clog2(DISPLAY_DEPTH);
  localparam int GLYPH_AW      = $clog2(GLYPH_DEPTH);
  localparam int AC_W          = 7;

  // Mode flag bit positions
  localparam int FLAG_DISPLAY = 0;
  localparam int FLAG_CURSOR  = 1;
  localparam int FLAG_BLINK   = 2;
  localparam int FLAG_TWO     = 3;
  localparam int FLAG_TALL    = 4;

  localparam logic [7:0]      SPACE_CHAR   = 8'h20;
  localparam logic [AC_W-1:0] LINE1_LAST   = 7'h27;
  localparam logic [7:0]      LINE2_ADJ    = 8'h18;
  localparam logic [7:0]      LINE2_BASE   = 8'h40;
  localparam logic [8:0]      LIMIT_TWO    = 9'd40;
  localparam logic [8:0]      LIMIT_ONE    = 9'd80;

  localparam logic       ACT_READ  = 1'b0;
  localparam logic       ACT_WRITE = 1'b1;
  localparam logic [1:0] REG_INSTR = 2'd0;
  localparam logic [1:0] REG_DATA  = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STEP,
    S_FETCH,
    S_LOAD,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_HOME,
    CMD_ENTRY,
    CMD_ONOFF,
    CMD_SHIFT,
    CMD_FUNC,
    CMD_CGRAM,
    CMD_DDRAM
  } cmd_t;

  // Command is set by the highest set bit of the instruction byte
  function automatic cmd_t decode_cmd(logic [7:0] v);
    cmd_t c;
    priority if (v[7]) c = CMD_DDRAM;
    else if (v[6])     c = CMD_CGRAM;
    else if (v[5])     c = CMD_FUNC;
    else if (v[4])     c = CMD_SHIFT;
    else if (v[3])     c = CMD_ONOFF;
    else if (v[2])     c = CMD_ENTRY;
    else if (v[1])     c = CMD_HOME;
    else if (v[0])     c = CMD_CLEAR;
    else               c = CMD_NONE;
    return c;
  endfunction

endpackage

>>> hw/rtl/lcdr_if.sv
interface lcdr_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] register_address;
  logic [7:0] write_data;

  modport source (output valid, action, register_address, write_data, input ready);
  modport sink   (input valid, action, register_address, write_data, output ready);
endinterface

interface lcdr_rsp_if;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic              bus_error;
  logic              display_on;
  logic              cursor_on;
  logic              blink_on;
  logic              two_line_mode;
  logic              tall_font;
  logic signed [7:0] view_offset;

  modport source (output valid, read_data, bus_error, display_on, cursor_on, blink_on,
                  two_line_mode, tall_font, view_offset, input ready);
  modport sink   (input valid, read_data, bus_error, display_on, cursor_on, blink_on,
                  two_line_mode, tall_font, view_offset, output ready);
endinterface

>>> hw/rtl/lcdr_ram.sv
module lcdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/char_lcd_controller_registers_top.sv
// Character LCD controller, register side.
// req channel: one bus access per request (action 0 read / 1 write,
//   register_address 0 instruction/address, 1 data, 2-3 unmapped,
//   write_data). Accepted when req.valid && req.ready.
// rsp channel: exactly one result per request: read_data, bus_error and
//   the mode flags and view offset as they stand after the access.
// Timing: ready only in the idle state; after the accept edge the request
//   steps through these states before its result is registered on rsp:
//     unmapped, status read, most instructions EXEC, DONE
//     data write ............................. EXEC, STEP, DONE
//     display/glyph address set .............. EXEC, FETCH, LOAD, DONE
//     data read .............................. EXEC, STEP, FETCH, LOAD, DONE
//   One pass of the shared +/-1 wrap unit per cycle, plus a registered RAM
//   read for refilling the data latch. Back in idle as the result is
//   registered; no new request is taken before the last one is through.
// A stalled rsp holds its result in the output register; the next request
//   is still accepted and then waits in its final state for the register.
// Reset (rst, sync, active high): display store reads as spaces, glyph
//   store as zero (per-entry valid bits, no clearing pass); counter, latches,
//   flags and offset cleared. Clear-display drops the display valid bits too.
module char_lcd_controller_registers_top (
  input logic         clk,
  input logic         rst,
  lcdr_req_if.sink    req,
  lcdr_rsp_if.source  rsp
);

  lcdr_pkg::state_t state, state_next;

  // captured request
  logic       act_q;
  logic [1:0] reg_q;
  logic [7:0] wd_q;

  // architectural state
  logic [lcdr_pkg::AC_W-1:0]        address_counter;
  logic [7:0]                       data_latch;
  logic [7:0]                       instruction_latch;
  logic                             step_down;
  logic                             shift_with_write;
  logic                             glyph_select;
  logic signed [7:0]                shift_amount;
  logic [4:0]                       mode_flags;
  logic [lcdr_pkg::DISPLAY_DEPTH-1:0] disp_valid;
  logic [lcdr_pkg::GLYPH_DEPTH-1:0]   glyph_valid;

  // per-request scratch
  logic [7:0] rd_q;
  logic       err_q;
  logic       fetch_valid;
  logic       fetch_glyph;

  // decode of the captured request
  lcdr_pkg::cmd_t cmd;
  logic is_err, is_read, is_instr, is_data_rd, is_data_wr, is_instr_wr;
  logic [lcdr_pkg::DISP_AW-1:0]  disp_idx;
  logic [lcdr_pkg::GLYPH_AW-1:0] glyph_idx;

  assign cmd         = lcdr_pkg::decode_cmd(wd_q);
  assign is_err      = reg_q[1];
  assign is_read     = (act_q == lcdr_pkg::ACT_READ);
  assign is_instr    = (reg_q == lcdr_pkg::REG_INSTR);
  assign is_data_rd  = !is_err && is_read && (reg_q == lcdr_pkg::REG_DATA);
  assign is_data_wr  = !is_err && !is_read && (reg_q == lcdr_pkg::REG_DATA);
  assign is_instr_wr = !is_err && !is_read && is_instr;
  assign disp_idx    = address_counter[lcdr_pkg::DISP_AW-1:0];
  assign glyph_idx   = address_counter[lcdr_pkg::GLYPH_AW-1:0];

  // ---------------------------------------------------------------------
  // Shared +/-1 wrap unit: counter steps and view offset moves
  // ---------------------------------------------------------------------
  logic              u_ofs, u_down;
  logic signed [8:0] u_op, u_bound, u_sum, u_res;

  always_comb begin
    u_bound = u_ofs ? (mode_flags[lcdr_pkg::FLAG_TWO] ? $signed(lcdr_pkg::LIMIT_TWO)
                                                       : $signed(lcdr_pkg::LIMIT_ONE))
                    : (glyph_select ? 9'(lcdr_pkg::GLYPH_DEPTH)
                                    : 9'(lcdr_pkg::DISPLAY_DEPTH));
    u_op  = u_ofs ? {shift_amount[7], shift_amount} : {2'b00, address_counter};
    u_sum = u_down ? u_op - 9'sd1 : u_op + 9'sd1;
    priority if (!u_down) begin
      u_res = (u_sum >= u_bound) ? '0 : u_sum;
    end else if (u_ofs) begin
      u_res = (u_sum <= -u_bound) ? '0 : u_sum;
    end else begin
      u_res = (u_op == 9'sd0 || u_op > u_bound) ? u_bound - 9'sd1 : u_sum;
    end
  end

  // address register read-back and address-set targets
  logic [7:0]                ac_read;
  logic [7:0]                dd_raw;
  logic [lcdr_pkg::AC_W-1:0] dd_addr, cg_addr;

  always_comb begin
    if (mode_flags[lcdr_pkg::FLAG_TWO] && !glyph_select &&
        address_counter > lcdr_pkg::LINE1_LAST) begin
      ac_read = {1'b0, address_counter} + lcdr_pkg::LINE2_ADJ;
    end else begin
      ac_read = {1'b0, address_counter};
    end
    dd_raw = {1'b0, wd_q[6:0]};
    if (mode_flags[lcdr_pkg::FLAG_TWO] && dd_raw >= lcdr_pkg::LINE2_BASE) begin
      dd_raw = dd_raw - lcdr_pkg::LINE2_ADJ;
    end
    dd_addr = (dd_raw >= 8'(lcdr_pkg::DISPLAY_DEPTH)) ? '0 : dd_raw[lcdr_pkg::AC_W-1:0];
    cg_addr = ({2'b00, wd_q[5:0]} >= 8'(lcdr_pkg::GLYPH_DEPTH)) ? '0 : {1'b0, wd_q[5:0]};
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  logic rsp_free;
  assign rsp_free = !rsp.valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      lcdr_pkg::S_IDLE: begin
        if (req.valid) state_next = lcdr_pkg::S_EXEC;
      end
      lcdr_pkg::S_EXEC: begin
        if (is_data_rd || is_data_wr) begin
          state_next = lcdr_pkg::S_STEP;
        end else if (is_instr_wr &&
                     (cmd == lcdr_pkg::CMD_CGRAM || cmd == lcdr_pkg::CMD_DDRAM)) begin
          state_next = lcdr_pkg::S_FETCH;
        end else begin
          state_next = lcdr_pkg::S_DONE;
        end
      end
      lcdr_pkg::S_STEP: begin
        state_next = is_data_rd ? lcdr_pkg::S_FETCH : lcdr_pkg::S_DONE;
      end
      lcdr_pkg::S_FETCH: state_next = lcdr_pkg::S_LOAD;
      lcdr_pkg::S_LOAD:  state_next = lcdr_pkg::S_DONE;
      lcdr_pkg::S_DONE: begin
        if (rsp_free) state_next = lcdr_pkg::S_IDLE;
      end
      default: state_next = lcdr_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------
  logic disp_we, glyph_we, ram_re;

  always_comb begin
    req.ready = 1'b0;
    u_ofs     = 1'b0;
    u_down    = step_down;
    disp_we   = 1'b0;
    glyph_we  = 1'b0;
    ram_re    = 1'b0;
    unique case (state)
      lcdr_pkg::S_IDLE: req.ready = 1'b1;
      lcdr_pkg::S_EXEC: begin
        if (is_instr_wr && cmd == lcdr_pkg::CMD_SHIFT) begin
          // 00 cursor left, 01 cursor right, 10 view up, 11 view down
          u_ofs  = wd_q[3];
          u_down = wd_q[3] ? wd_q[2] : !wd_q[2];
        end else if (is_data_wr) begin
          u_ofs    = 1'b1;
          u_down   = step_down;
          disp_we  = !glyph_select;
          glyph_we = glyph_select;
        end
      end
      lcdr_pkg::S_FETCH: ram_re = 1'b1;
      lcdr_pkg::S_STEP, lcdr_pkg::S_LOAD, lcdr_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------
  logic [7:0] disp_q, glyph_q;

  lcdr_ram #(.WIDTH(8), .DEPTH(lcdr_pkg::DISPLAY_DEPTH)) u_disp_ram (
    .clk     (clk),
    .we      (disp_we),
    .wr_addr (disp_idx),
    .wr_data (wd_q),
    .re      (ram_re),
    .rd_addr (disp_idx),
    .rd_data (disp_q)
  );

  lcdr_ram #(.WIDTH(8), .DEPTH(lcdr_pkg::GLYPH_DEPTH)) u_glyph_ram (
    .clk     (clk),
    .we      (glyph_we),
    .wr_addr (glyph_idx),
    .wr_data (wd_q),
    .re      (ram_re),
    .rd_addr (glyph_idx),
    .rd_data (glyph_q)
  );

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act_q <= req.action;
      reg_q <= req.register_address;
      wd_q  <= req.write_data;
    end
    if (state == lcdr_pkg::S_FETCH) begin
      fetch_valid <= glyph_select ? glyph_valid[glyph_idx] : disp_valid[disp_idx];
      fetch_glyph <= glyph_select;
    end
    if (state == lcdr_pkg::S_EXEC) begin
      err_q <= is_err;
      if (!is_err && is_read) begin
        rd_q <= is_instr ? ac_read : data_latch;
      end else begin
        rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= lcdr_pkg::S_IDLE;
      address_counter   <= '0;
      data_latch        <= '0;
      instruction_latch <= '0;
      step_down         <= 1'b0;
      shift_with_write  <= 1'b0;
      glyph_select      <= 1'b0;
      shift_amount      <= '0;
      mode_flags        <= '0;
      disp_valid        <= '0;
      glyph_valid       <= '0;
      rsp.valid         <= 1'b0;
    end else begin
      state <= state_next;

      unique case (state)
        lcdr_pkg::S_EXEC: begin
          if (is_instr_wr) begin
            instruction_latch <= wd_q;
            unique case (cmd)
              lcdr_pkg::CMD_CLEAR: begin
                disp_valid      <= '0;
                address_counter <= '0;
                step_down       <= 1'b0;
                glyph_select    <= 1'b0;
                shift_amount    <= '0;
              end
              lcdr_pkg::CMD_HOME: begin
                address_counter <= '0;
                glyph_select    <= 1'b0;
                shift_amount    <= '0;
              end
              lcdr_pkg::CMD_ENTRY: begin
                shift_with_write <= wd_q[0];
                step_down        <= !wd_q[1];
              end
              lcdr_pkg::CMD_ONOFF: begin
                mode_flags[lcdr_pkg::FLAG_DISPLAY] <= wd_q[2];
                mode_flags[lcdr_pkg::FLAG_CURSOR]  <= wd_q[1];
                mode_flags[lcdr_pkg::FLAG_BLINK]   <= wd_q[0];
              end
              lcdr_pkg::CMD_SHIFT: begin
                if (u_ofs) shift_amount <= u_res[7:0];
                else       address_counter <= u_res[lcdr_pkg::AC_W-1:0];
              end
              lcdr_pkg::CMD_FUNC: begin
                mode_flags[lcdr_pkg::FLAG_TWO]  <= wd_q[3];
                mode_flags[lcdr_pkg::FLAG_TALL] <= wd_q[2];
              end
              lcdr_pkg::CMD_CGRAM: begin
                address_counter <= cg_addr;
                glyph_select    <= 1'b1;
              end
              lcdr_pkg::CMD_DDRAM: begin
                address_counter <= dd_addr;
                glyph_select    <= 1'b0;
              end
              lcdr_pkg::CMD_NONE: ;
              default: ;
            endcase
          end else if (is_data_wr) begin
            data_latch <= wd_q;
            if (glyph_select) begin
              glyph_valid[glyph_idx] <= 1'b1;
            end else begin
              disp_valid[disp_idx] <= 1'b1;
              if (shift_with_write) shift_amount <= u_res[7:0];
            end
          end
        end
        lcdr_pkg::S_STEP: address_counter <= u_res[lcdr_pkg::AC_W-1:0];
        lcdr_pkg::S_LOAD: begin
          if (fetch_glyph) data_latch <= fetch_valid ? glyph_q : 8'h00;
          else             data_latch <= fetch_valid ? disp_q : lcdr_pkg::SPACE_CHAR;
        end
        lcdr_pkg::S_IDLE, lcdr_pkg::S_FETCH, lcdr_pkg::S_DONE: ;
        default: ;
      endcase

      if (state == lcdr_pkg::S_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == lcdr_pkg::S_DONE && rsp_free) begin
      rsp.read_data     <= rd_q;
      rsp.bus_error     <= err_q;
      rsp.display_on    <= mode_flags[lcdr_pkg::FLAG_DISPLAY];
      rsp.cursor_on     <= mode_flags[lcdr_pkg::FLAG_CURSOR];
      rsp.blink_on      <= mode_flags[lcdr_pkg::FLAG_BLINK];
      rsp.two_line_mode <= mode_flags[lcdr_pkg::FLAG_TWO];
      rsp.tall_font     <= mode_flags[lcdr_pkg::FLAG_TALL];
      rsp.view_offset   <= shift_amount;
    end
  end

`ifndef SYNTH
  // counter never leaves the selected store
  a_ac_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, address_counter} < (glyph_select ? 8'(lcdr_pkg::GLYPH_DEPTH)
                                             : 8'(lcdr_pkg::DISPLAY_DEPTH))))
    else $error("address counter out of range");

  // view offset stays strictly inside +/-80
  a_ofs_range: assert property (@(posedge clk) disable iff (rst)
    (shift_amount > -8'sd80 && shift_amount < 8'sd80))
    else $error("view offset out of range");

  // an accepted request always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == lcdr_pkg::S_EXEC))
    else $error("accepted request not executed");

  // a new result only appears out of the final state
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == lcdr_pkg::S_DONE))
    else $error("result without finished request");
`endif

endmodule
